### rtl/core/indexed_linked_list_table_top_defines.svh
// ----------------------------------------------------------------------------
// Indexed linked list table: assertion macros
// Shared property templates for the port checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_TABLE_TOP_DEFINES_SVH
`define INDEXED_LINKED_LIST_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilt check failed");

`endif

### rtl/core/ilt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_pkg
// Types, operation codes and defaults of the indexed linked list table.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int SLOT_COUNT_DEF = 256;
  localparam int VALUE_BITS_DEF = 32;

  localparam int FUNC_W     = 4;
  localparam int IDX_W      = 9;
  localparam int SLOT_OUT_W = 8;

  localparam logic [FUNC_W-1:0] FN_INS_TAIL   = 4'd0;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 4'd2;
  localparam logic [FUNC_W-1:0] FN_RM_VALUE   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_POP        = 4'd4;
  localparam logic [FUNC_W-1:0] FN_RM_SLOT    = 4'd5;
  localparam logic [FUNC_W-1:0] FN_RM_TAIL    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_FIND       = 4'd7;
  localparam logic [FUNC_W-1:0] FN_SWAP       = 4'd8;
  localparam logic [FUNC_W-1:0] FN_READ       = 4'd9;

  localparam logic signed [IDX_W-1:0] IDX_HEAD = -9'sd1;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_BAD_SLOT  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_HEAD,
    S_CHK2,
    S_WALK,
    S_PLACE1,
    S_PLACE2,
    S_SCAN_RD,
    S_SCAN_CK,
    S_REL1,
    S_REL2,
    S_SWAP1,
    S_SWAP2
  } state_e;

endpackage

### rtl/core/indexed_linked_list_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_linked_list_table_top
// Slot table of nonzero values threaded into a doubly linked list.
// ----------------------------------------------------------------------------
// Operations rejected at decode finish straight from idle; a value search walks
// the list one entry at a time from the head sentinel, and a swap walks it twice.
// An insert then rescans for the next free slot, skipping occupied slots.
// Reset clears all slot memories with busy_o held high.
// One operation at a time while busy_o is high; the receiver cannot stall.
module indexed_linked_list_table_top #(
  parameter int SLOT_COUNT = ilt_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_BITS = ilt_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ilt_pkg::FUNC_W-1:0]          func_i,
  input  logic [VALUE_BITS-1:0]               value_a_i,
  input  logic [VALUE_BITS-1:0]               value_b_i,
  input  logic signed [ilt_pkg::IDX_W-1:0]    slot_index_i,
  input  logic                                backward_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [ilt_pkg::SLOT_OUT_W-1:0]      result_slot_o,
  output logic [VALUE_BITS-1:0]               result_value_o,
  output logic [ilt_pkg::SLOT_OUT_W-1:0]      link_o,
  output logic [ilt_pkg::SLOT_OUT_W-1:0]      entry_count_o
);
  import ilt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);

  status_e               sts;
  logic [SW-1:0]         rslot, lnk;
  logic [SW:0]           count;
  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_value;
  logic [SW-1:0]         rd_prev, rd_next;
  logic                  val_we, prev_we, next_we;
  logic [SW-1:0]         val_waddr, prev_waddr, next_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [SW-1:0]         prev_wdata, next_wdata;

  ilt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .func_i        (func_i),
    .value_a_i     (value_a_i),
    .value_b_i     (value_b_i),
    .slot_index_i  (slot_index_i),
    .backward_i    (backward_i),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .status_o      (sts),
    .result_slot_o (rslot),
    .result_value_o(result_value_o),
    .link_o        (lnk),
    .count_o       (count),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_value_i    (rd_value),
    .rd_prev_i     (rd_prev),
    .rd_next_i     (rd_next),
    .val_we_o      (val_we),
    .val_waddr_o   (val_waddr),
    .val_wdata_o   (val_wdata),
    .prev_we_o     (prev_we),
    .prev_waddr_o  (prev_waddr),
    .prev_wdata_o  (prev_wdata),
    .next_we_o     (next_we),
    .next_waddr_o  (next_waddr),
    .next_wdata_o  (next_wdata)
  );

  ilt_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOT_COUNT)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(val_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_value)
  );

  ilt_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (prev_we),
    .waddr_i(prev_waddr),
    .wdata_i(prev_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_prev)
  );

  ilt_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (next_we),
    .waddr_i(next_waddr),
    .wdata_i(next_wdata),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_next)
  );

  assign status_o      = sts;
  assign result_slot_o = SLOT_OUT_W'(rslot);
  assign link_o        = SLOT_OUT_W'(lnk);
  assign entry_count_o = SLOT_OUT_W'(count);

endmodule

### rtl/core/ilt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_ram
// Single write port, single read port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module ilt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### rtl/core/ilt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_ctrl
// Sequencer of the list table: decodes one operation, walks and updates the
// slot memories by read-modify-write steps and produces the result.
// ----------------------------------------------------------------------------
module ilt_ctrl #(
  parameter int SLOT_COUNT = ilt_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_BITS = ilt_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ilt_pkg::FUNC_W-1:0]           func_i,
  input  logic [VALUE_BITS-1:0]                value_a_i,
  input  logic [VALUE_BITS-1:0]                value_b_i,
  input  logic signed [ilt_pkg::IDX_W-1:0]     slot_index_i,
  input  logic                                 backward_i,
  output logic                                 busy_o,
  output logic                                 done_o,
  output ilt_pkg::status_e                     status_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        result_slot_o,
  output logic [VALUE_BITS-1:0]                result_value_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        link_o,
  output logic [$clog2(SLOT_COUNT):0]          count_o,
  output logic                                 rd_en_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        rd_addr_o,
  input  logic [VALUE_BITS-1:0]                rd_value_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]        rd_prev_i,
  input  logic [$clog2(SLOT_COUNT)-1:0]        rd_next_i,
  output logic                                 val_we_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        val_waddr_o,
  output logic [VALUE_BITS-1:0]                val_wdata_o,
  output logic                                 prev_we_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        prev_waddr_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        prev_wdata_o,
  output logic                                 next_we_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        next_waddr_o,
  output logic [$clog2(SLOT_COUNT)-1:0]        next_wdata_o
);
  import ilt_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam logic [SW:0]   LF_NONE  = (SW+1)'(SLOT_COUNT);
  localparam logic [SW-1:0] CLR_LAST = SW'(SLOT_COUNT - 1);

  state_e state_q, state_d;
  logic [SW-1:0] clr_q, clr_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [SW:0]   count_q, count_d;
  logic [SW:0]   lf_q, lf_d;
  logic          done_q, done_d;

  logic [FUNC_W-1:0]        func_q, func_d;
  logic [VALUE_BITS-1:0]    va_q, va_d, vb_q, vb_d;
  logic signed [IDX_W-1:0]  idx_q, idx_d;
  logic                     back_q, back_d;
  logic                     phase_q, phase_d;
  logic [SW-1:0]            cur_q, cur_d;
  logic [SW-1:0]            a_q, a_d;
  logic [SW-1:0]            before_q, before_d, after_q, after_d;
  status_e                  sts_q, sts_d;
  logic [SW-1:0]            rslot_q, rslot_d, link_q, link_d;
  logic [VALUE_BITS-1:0]    rval_q, rval_d;

  logic          fin;
  status_e       fin_sts;
  logic          in_idx_ok, in_va_nz, in_vb_nz, full, found, slot_used;
  logic [SW-1:0] in_slot, lf_slot;
  logic [VALUE_BITS-1:0] tgt;

  assign in_idx_ok = (slot_index_i >= 1) && (slot_index_i < SLOT_COUNT);
  assign in_va_nz  = value_a_i != '0;
  assign in_vb_nz  = value_b_i != '0;
  assign in_slot   = SW'(slot_index_i);
  assign full      = lf_q == LF_NONE;
  assign lf_slot   = lf_q[SW-1:0];
  assign tgt       = phase_q ? vb_q : va_q;
  assign found     = rd_value_i == tgt;
  assign slot_used = rd_value_i != '0;

  // Next state
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    fin     = 1'b0;
    fin_sts = STS_OK;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FN_INS_TAIL: begin
              if (!in_va_nz) begin
                fin = 1'b1; fin_sts = STS_NOT_FOUND;
              end else if (full) begin
                fin = 1'b1; fin_sts = STS_FULL;
              end else begin
                state_d = S_PLACE1; cur_d = lf_slot;
              end
            end
            FN_INS_AFTER, FN_INS_BEFORE: begin
              if (!in_va_nz) begin
                fin = 1'b1; fin_sts = STS_NOT_FOUND;
              end else if (func_i == FN_INS_AFTER && slot_index_i == 0) begin
                state_d = S_CHK; cur_d = '0;
              end else if (!in_idx_ok) begin
                fin = 1'b1; fin_sts = STS_BAD_SLOT;
              end else begin
                state_d = S_CHK; cur_d = in_slot;
              end
            end
            FN_RM_VALUE, FN_FIND, FN_SWAP: begin
              if (!in_va_nz || (func_i == FN_SWAP && !in_vb_nz)) begin
                fin = 1'b1; fin_sts = STS_NOT_FOUND;
              end else begin
                state_d = S_WALK; cur_d = '0;
              end
            end
            FN_POP: begin
              state_d = S_HEAD; cur_d = '0;
            end
            FN_RM_TAIL: begin
              if (tail_q == '0) begin
                fin = 1'b1; fin_sts = STS_NOT_FOUND;
              end else begin
                state_d = S_CHK2; cur_d = tail_q;
              end
            end
            FN_RM_SLOT: begin
              if (!in_idx_ok) begin
                fin = 1'b1; fin_sts = STS_BAD_SLOT;
              end else begin
                state_d = S_CHK2; cur_d = in_slot;
              end
            end
            FN_READ: begin
              if (slot_index_i == IDX_HEAD) begin
                if (!backward_i) begin
                  state_d = S_HEAD; cur_d = '0;
                end else if (tail_q == '0) begin
                  fin = 1'b1; fin_sts = STS_NOT_FOUND;
                end else begin
                  state_d = S_CHK2; cur_d = tail_q;
                end
              end else if (!in_idx_ok) begin
                fin = 1'b1; fin_sts = STS_BAD_SLOT;
              end else begin
                state_d = S_CHK2; cur_d = in_slot;
              end
            end
            default: begin
              fin = 1'b1; fin_sts = STS_NOT_FOUND;
            end
          endcase
        end
      end
      S_CHK: begin
        if (!(slot_used || (func_q == FN_INS_AFTER && cur_q == '0))) begin
          fin = 1'b1; fin_sts = STS_BAD_SLOT;
        end else if (full) begin
          fin = 1'b1; fin_sts = STS_FULL;
        end else begin
          state_d = S_PLACE1; cur_d = lf_slot;
        end
      end
      S_HEAD: begin
        if (rd_next_i == '0) begin
          fin = 1'b1; fin_sts = STS_NOT_FOUND;
        end else begin
          state_d = S_CHK2; cur_d = rd_next_i;
        end
      end
      S_CHK2: begin
        if (!slot_used) begin
          fin = 1'b1;
          fin_sts = (func_q == FN_RM_SLOT ||
                     (func_q == FN_READ && idx_q != IDX_HEAD)) ? STS_BAD_SLOT
                                                              : STS_NOT_FOUND;
        end else if (func_q == FN_READ) begin
          fin = 1'b1;
        end else begin
          state_d = S_REL1;
        end
      end
      S_WALK: begin
        if (found) begin
          if (func_q == FN_RM_VALUE) begin
            state_d = S_REL1;
          end else if (func_q == FN_FIND) begin
            fin = 1'b1;
          end else if (!phase_q) begin
            cur_d = '0;  // restart the walk for the second value
          end else begin
            state_d = S_SWAP1;
          end
        end else if (rd_next_i == '0) begin
          fin = 1'b1; fin_sts = STS_NOT_FOUND;
        end else begin
          cur_d = rd_next_i;
        end
      end
      S_PLACE1:  state_d = S_PLACE2;
      S_PLACE2:  state_d = S_SCAN_RD;
      S_SCAN_RD: begin
        if (full) fin = 1'b1;
        else      state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (!slot_used) fin = 1'b1;
        else            state_d = S_SCAN_RD;
      end
      S_REL1:  state_d = S_REL2;
      S_REL2:  fin = 1'b1;
      S_SWAP1: state_d = S_SWAP2;
      S_SWAP2: fin = 1'b1;
      default: state_d = S_IDLE;
    endcase
    if (fin) state_d = S_IDLE;
  end

  // Outputs and datapath
  always_comb begin
    clr_d    = clr_q;
    tail_d   = tail_q;
    count_d  = count_q;
    lf_d     = lf_q;
    done_d   = 1'b0;
    func_d   = func_q;
    va_d     = va_q;
    vb_d     = vb_q;
    idx_d    = idx_q;
    back_d   = back_q;
    phase_d  = phase_q;
    a_d      = a_q;
    before_d = before_q;
    after_d  = after_q;
    sts_d    = sts_q;
    rslot_d  = rslot_q;
    rval_d   = rval_q;
    link_d   = link_q;

    val_we_o     = 1'b0;
    val_waddr_o  = cur_q;
    val_wdata_o  = '0;
    prev_we_o    = 1'b0;
    prev_waddr_o = cur_q;
    prev_wdata_o = '0;
    next_we_o    = 1'b0;
    next_waddr_o = cur_q;
    next_wdata_o = '0;

    rd_en_o   = (state_d == S_CHK) || (state_d == S_HEAD) || (state_d == S_CHK2) ||
                (state_d == S_WALK) || (state_d == S_SCAN_CK);
    rd_addr_o = (state_d == S_SCAN_CK) ? lf_slot : cur_d;

    unique case (state_q)
      S_CLEAR: begin
        val_we_o  = 1'b1; val_waddr_o  = clr_q;
        prev_we_o = 1'b1; prev_waddr_o = clr_q;
        next_we_o = 1'b1; next_waddr_o = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_i;
          va_d     = value_a_i;
          vb_d     = value_b_i;
          idx_d    = slot_index_i;
          back_d   = backward_i;
          phase_d  = 1'b0;
          before_d = tail_q;
          after_d  = '0;
        end
      end
      S_CHK: begin
        before_d = (func_q == FN_INS_AFTER) ? cur_q : rd_prev_i;
        after_d  = (func_q == FN_INS_AFTER) ? rd_next_i : cur_q;
      end
      S_WALK: begin
        if (found && func_q == FN_SWAP && !phase_q) begin
          phase_d = 1'b1;
          a_d     = cur_q;
        end
      end
      S_PLACE1: begin
        val_we_o  = 1'b1; val_wdata_o  = va_q;
        prev_we_o = 1'b1; prev_wdata_o = before_q;
        next_we_o = 1'b1; next_wdata_o = after_q;
      end
      S_PLACE2: begin
        next_we_o    = 1'b1;
        next_waddr_o = before_q;
        next_wdata_o = cur_q;
        if (after_q != '0) begin
          prev_we_o    = 1'b1;
          prev_waddr_o = after_q;
          prev_wdata_o = cur_q;
        end else begin
          tail_d = cur_q;
        end
        count_d = count_q + 1'b1;
        lf_d    = {1'b0, cur_q} + 1'b1;
      end
      S_SCAN_CK: begin
        if (slot_used) lf_d = lf_q + 1'b1;
      end
      S_REL1: begin
        val_we_o  = 1'b1;
        prev_we_o = 1'b1;
        next_we_o = 1'b1;
      end
      S_REL2: begin
        // unlink: read data still holds the removed slot's links
        next_we_o    = 1'b1;
        next_waddr_o = rd_prev_i;
        next_wdata_o = rd_next_i;
        if (tail_q == cur_q) begin
          tail_d = rd_prev_i;
        end else begin
          prev_we_o    = 1'b1;
          prev_waddr_o = rd_next_i;
          prev_wdata_o = rd_prev_i;
        end
        count_d = count_q - 1'b1;
        if ({1'b0, cur_q} < lf_q) lf_d = {1'b0, cur_q};
      end
      S_SWAP1: begin
        val_we_o    = 1'b1;
        val_waddr_o = a_q;
        val_wdata_o = vb_q;
      end
      S_SWAP2: begin
        val_we_o    = 1'b1;
        val_wdata_o = va_q;
      end
      default: ;
    endcase

    if (fin) begin
      done_d  = 1'b1;
      sts_d   = fin_sts;
      rslot_d = '0;
      rval_d  = '0;
      link_d  = '0;
      if (fin_sts == STS_OK) begin
        if (func_q != FN_SWAP) rslot_d = cur_q;
        if (func_q inside {FN_RM_VALUE, FN_POP, FN_RM_SLOT, FN_RM_TAIL, FN_READ}) begin
          rval_d = rd_value_i;
        end
        if (func_q == FN_READ) link_d = back_q ? rd_prev_i : rd_next_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      tail_q  <= '0;
      count_q <= '0;
      lf_q    <= (SW+1)'(1);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      lf_q    <= lf_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    va_q     <= va_d;
    vb_q     <= vb_d;
    idx_q    <= idx_d;
    back_q   <= back_d;
    phase_q  <= phase_d;
    cur_q    <= cur_d;
    a_q      <= a_d;
    before_q <= before_d;
    after_q  <= after_d;
    sts_q    <= sts_d;
    rslot_q  <= rslot_d;
    rval_q   <= rval_d;
    link_q   <= link_d;
  end

  assign busy_o         = state_q != S_IDLE;
  assign done_o         = done_q;
  assign status_o       = sts_q;
  assign result_slot_o  = rslot_q;
  assign result_value_o = rval_q;
  assign link_o         = link_q;
  assign count_o        = count_q;

endmodule

### rtl/core/ilt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilt_checker
// Port-level checks of the indexed linked list table, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_linked_list_table_top_defines.svh"

module ilt_checker #(
  parameter int SLOT_COUNT = ilt_pkg::SLOT_COUNT_DEF,
  parameter int VALUE_BITS = ilt_pkg::VALUE_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic [ilt_pkg::FUNC_W-1:0]          func_i,
  input logic [VALUE_BITS-1:0]               value_a_i,
  input logic [VALUE_BITS-1:0]               value_b_i,
  input logic signed [ilt_pkg::IDX_W-1:0]    slot_index_i,
  input logic                                backward_i,
  input logic                                done_o,
  input logic [1:0]                          status_o,
  input logic [ilt_pkg::SLOT_OUT_W-1:0]      result_slot_o,
  input logic [VALUE_BITS-1:0]               result_value_o,
  input logic [ilt_pkg::SLOT_OUT_W-1:0]      link_o,
  input logic [ilt_pkg::SLOT_OUT_W-1:0]      entry_count_o
);
  import ilt_pkg::*;

  // a failed operation reports nothing but its status
  `ILT_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, done_o && status_o != STS_OK, result_slot_o == '0 && result_value_o == '0 && link_o == '0)

  // a full table holds every slot but the head sentinel
  `ILT_ASSERT_NOW(a_full_count, clk_i, rst_ni, done_o && status_o == STS_FULL, entry_count_o == SLOT_OUT_W'(SLOT_COUNT - 1))

  // a result only follows a transfer or work in progress
  `ILT_ASSERT_NOW(a_done_cause, clk_i, rst_ni, done_o, $past(busy_o) || $past(start_i))

  // a value removal with a nonzero value always walks the list
  `ILT_ASSERT_NEXT(a_walk_busy, clk_i, rst_ni, start_i && !busy_o && func_i == FN_RM_VALUE && value_a_i != '0, busy_o)

endmodule

bind indexed_linked_list_table_top ilt_checker #(
  .SLOT_COUNT(SLOT_COUNT),
  .VALUE_BITS(VALUE_BITS)
) u_ilt_checker (.*);
